>>> design/bmpp_pkg.sv
// ----------------------------------------------------------------------------
// bmpp_pkg: shared types and constants of the path projector
// Register indexes, job descriptor, CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none
package bmpp_pkg;

   localparam logic [1:0] CSR_SPEED_FLOOR   = 2'd0;
   localparam logic [1:0] CSR_STEP_COUNT    = 2'd1;
   localparam logic [1:0] CSR_STEP_TIME     = 2'd2;
   localparam logic [1:0] CSR_INV_WHEELBASE = 2'd3;

   localparam logic signed [35:0] INV_GAIN_Q30 = 36'sd652032874;

   // one prepared run, passed from front to back
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [15:0]        heading;
      logic [31:0]        step_dist;
      logic [15:0]        inc;
      logic [6:0]         count;
   } job_type;

   typedef enum logic [2:0] {
      FR_IDLE, FR_MUL1, FR_MUL2, FR_MUL3, FR_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_ROT, BK_MUL, BK_ADD, BK_OUT
   } back_state_type;

   // atan(2^-i) in 2^-32 turn
   function automatic logic [29:0] atan_turn(input logic [4:0] i);
      case (i)
         5'd0:  atan_turn = 30'd536870912;
         5'd1:  atan_turn = 30'd316933406;
         5'd2:  atan_turn = 30'd167458907;
         5'd3:  atan_turn = 30'd85004756;
         5'd4:  atan_turn = 30'd42667331;
         5'd5:  atan_turn = 30'd21354465;
         5'd6:  atan_turn = 30'd10679838;
         5'd7:  atan_turn = 30'd5340245;
         5'd8:  atan_turn = 30'd2670163;
         5'd9:  atan_turn = 30'd1335087;
         5'd10: atan_turn = 30'd667544;
         5'd11: atan_turn = 30'd333772;
         5'd12: atan_turn = 30'd166886;
         5'd13: atan_turn = 30'd83443;
         5'd14: atan_turn = 30'd41722;
         5'd15: atan_turn = 30'd20861;
         5'd16: atan_turn = 30'd10430;
         5'd17: atan_turn = 30'd5215;
         5'd18: atan_turn = 30'd2608;
         5'd19: atan_turn = 30'd1304;
         5'd20: atan_turn = 30'd652;
         5'd21: atan_turn = 30'd326;
         5'd22: atan_turn = 30'd163;
         5'd23: atan_turn = 30'd81;
         default: atan_turn = 30'd0;
      endcase
   endfunction

endpackage
`default_nettype wire

>>> design/bicycle_model_path_projector.sv
// ----------------------------------------------------------------------------
// bicycle_model_path_projector: kinematic bicycle path prediction
// Euler steps of a bicycle model, CORDIC cos/sin, saturating positions.
// ----------------------------------------------------------------------------
//  channel  ports            transfer when
//  req      req_push/full    push & !full   vehicle state in
//  rsp      rsp_empty/pop    pop & !empty   one predicted pose out
//  csr      csr_we/idx/wdata csr_we         register write
//
// Front takes one item at a time (three multiply steps, one push).
// Each pose runs through the shared iterative CORDIC, a multiply and a
// saturating add in the back engine; a run is step_count poses, clamped
// to 1..MAX_STEPS. Reset is synchronous and clears control only.
// A stalled rsp holds the engine; the two-entry job queue lets the front run ahead.
// ----------------------------------------------------------------------------
`default_nettype none
module bicycle_model_path_projector #(
   parameter int MAX_STEPS         = 64,
   parameter int CORDIC_ITERATIONS = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_push,
   output logic               req_full,
   input  wire  signed [31:0] req_start_x,
   input  wire  signed [31:0] req_start_y,
   input  wire         [15:0] req_start_heading,
   input  wire         [15:0] req_start_speed,
   input  wire  signed [15:0] req_steer_angle,
   output logic               rsp_empty,
   input  wire                rsp_pop,
   output logic signed [31:0] rsp_pose_x,
   output logic signed [31:0] rsp_pose_y,
   output logic        [15:0] rsp_pose_heading,
   output logic        [5:0]  rsp_step_index,
   output logic               rsp_last_step,
   input  wire                csr_we,
   input  wire         [1:0]  csr_idx,
   input  wire         [15:0] csr_wdata
);
   import bmpp_pkg::*;

   logic [15:0] speed_floor_ff, step_time_ff, inv_wb_ff;
   logic [6:0]  step_count_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_floor_ff <= 16'd128;
         step_count_ff  <= 7'd20;
         step_time_ff   <= 16'd6554;
         inv_wb_ff      <= 16'd32768;
      end else if (csr_we) begin
         case (csr_idx)
            CSR_SPEED_FLOOR:   speed_floor_ff <= csr_wdata;
            CSR_STEP_COUNT:    step_count_ff  <= csr_wdata[6:0];
            CSR_STEP_TIME:     step_time_ff   <= csr_wdata;
            CSR_INV_WHEELBASE: inv_wb_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   job_type f_job, q_job;
   logic    f_push, q_full, q_pop, q_empty;

   bmpp_front #(.MAX_STEPS(MAX_STEPS)) u_front (
      .clock, .reset, .req_push, .req_full,
      .req_start_x, .req_start_y, .req_start_heading, .req_start_speed,
      .req_steer_angle,
      .speed_floor(speed_floor_ff), .step_count(step_count_ff),
      .step_time(step_time_ff), .inv_wheelbase(inv_wb_ff),
      .job_push(f_push), .job_full(q_full), .job(f_job)
   );

   bmpp_queue u_queue (
      .clock, .reset, .push(f_push), .full(q_full), .din(f_job),
      .pop(q_pop), .empty(q_empty), .dout(q_job)
   );

   bmpp_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
      .clock, .reset, .job_empty(q_empty), .job_pop(q_pop), .job(q_job),
      .rsp_empty, .rsp_pop, .rsp_pose_x, .rsp_pose_y, .rsp_pose_heading,
      .rsp_step_index, .rsp_last_step
   );

`ifndef SYNTHESIS
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_last_step) |-> (rsp_step_index < 6'(MAX_STEPS - 1) + 6'd1
         || MAX_STEPS == 64))
      else $error("last pose index out of range");
   a_cnt_reg: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_empty) |-> $past(rsp_pop))
      else $error("pose vanished without a transfer");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      (q_pop) |-> !q_empty)
      else $error("engine took job from empty queue");
`endif
endmodule
`default_nettype wire

>>> design/bmpp_front.sv
// ----------------------------------------------------------------------------
// bmpp_front: input stage
// Takes a state item, applies the speed floor and clamps, works out the
// step distance and heading increment, hands a job to the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module bmpp_front #(
   parameter int MAX_STEPS = 64
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_push,
   output logic                    req_full,
   input  wire  signed [31:0]      req_start_x,
   input  wire  signed [31:0]      req_start_y,
   input  wire         [15:0]      req_start_heading,
   input  wire         [15:0]      req_start_speed,
   input  wire  signed [15:0]      req_steer_angle,
   input  wire         [15:0]      speed_floor,
   input  wire         [6:0]       step_count,
   input  wire         [15:0]      step_time,
   input  wire         [15:0]      inv_wheelbase,
   output logic                    job_push,
   input  wire                     job_full,
   output bmpp_pkg::job_type       job
);
   import bmpp_pkg::*;

   front_state_type state_ff, state_in;
   job_type         job_ff, job_in;
   logic signed [15:0] steer_ff, steer_in;
   logic signed [48:0] prod_ff, prod_in;   // d*steer
   logic [15:0]        spd;
   logic [31:0]        dist_full;
   logic signed [65:0] big;
   logic [6:0]         cnt;

   always_comb begin
      spd = (req_start_speed < speed_floor) ? speed_floor : req_start_speed;
      if (step_count == 7'd0)
         cnt = 7'd1;
      else if (step_count > 7'(MAX_STEPS))
         cnt = 7'(MAX_STEPS);
      else
         cnt = step_count;
      dist_full = (32'(spd) * 32'(step_time) + 32'd128) >> 8;
      big = 66'(prod_ff) * $signed({1'b0, inv_wheelbase}) + (66'sd1 <<< 31);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_IDLE: if (req_push) state_in = FR_MUL1;
         FR_MUL1: state_in = FR_MUL2;
         FR_MUL2: state_in = FR_MUL3;
         FR_MUL3: state_in = FR_PUSH;
         FR_PUSH: if (!job_full) state_in = FR_IDLE;
         default: state_in = FR_IDLE;
      endcase
   end

   always_comb begin
      job_in   = job_ff;
      steer_in = steer_ff;
      prod_in  = prod_ff;
      case (state_ff)
         FR_IDLE: if (req_push) begin
            job_in.x         = req_start_x;
            job_in.y         = req_start_y;
            job_in.heading   = req_start_heading;
            job_in.step_dist = dist_full;
            job_in.count     = cnt;
            steer_in         = req_steer_angle;
         end
         FR_MUL1: prod_in = $signed({1'b0, job_ff.step_dist}) * 49'(steer_ff);
         FR_MUL2: job_in.inc = big[47:32];
         default: ;
      endcase
   end

   assign req_full = (state_ff != FR_IDLE);
   assign job_push = (state_ff == FR_PUSH) && !job_full;
   assign job      = job_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= FR_IDLE;
      else       state_ff <= state_in;
      job_ff   <= job_in;
      steer_ff <= steer_in;
      prod_ff  <= prod_in;
   end

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      job_push |-> (job.count != 7'd0 && job.count <= 7'(MAX_STEPS)))
      else $error("job count out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FR_PUSH && job_full) |=> $stable(job_ff))
      else $error("job changed while queue full");
   a_full: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> req_full)
      else $error("front took item but not busy");
`endif
endmodule
`default_nettype wire

>>> design/bmpp_queue.sv
// ----------------------------------------------------------------------------
// bmpp_queue: two-entry job queue
// Decouples the front stage from the stepping engine.
// ----------------------------------------------------------------------------
`default_nettype none
module bmpp_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   output logic               full,
   input  bmpp_pkg::job_type  din,
   input  wire                pop,
   output logic               empty,
   output bmpp_pkg::job_type  dout
);
   import bmpp_pkg::*;

   job_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ do_push;
      rp_in  = rp_ff ^ do_pop;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) mem_ff[wp_ff] <= din;
   end

`ifndef SYNTHESIS
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (wp_ff ^ rp_ff) == (cnt_ff == 2'd1))
      else $error("queue pointers and count disagree");
   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count overflow");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> !empty)
      else $error("queue lost a job");
`endif
endmodule
`default_nettype wire

>>> design/bmpp_back.sv
// ----------------------------------------------------------------------------
// bmpp_back: stepping engine
// Iterative CORDIC, multiply, saturating add, one pose register.
// ----------------------------------------------------------------------------
`default_nettype none
module bmpp_back #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                job_empty,
   output logic               job_pop,
   input  bmpp_pkg::job_type  job,
   output logic               rsp_empty,
   input  wire                rsp_pop,
   output logic signed [31:0] rsp_pose_x,
   output logic signed [31:0] rsp_pose_y,
   output logic [15:0]        rsp_pose_heading,
   output logic [5:0]         rsp_step_index,
   output logic               rsp_last_step
);
   import bmpp_pkg::*;

   localparam int IW = $clog2(CORDIC_ITERATIONS + 1);

   back_state_type state_ff, state_in;
   logic signed [31:0] x_ff, x_in, y_ff, y_in;
   logic [15:0]        hd_ff, hd_in, inc_ff, inc_in;
   logic [31:0]        d_ff, d_in;
   logic [6:0]         cnt_ff, cnt_in, k_ff, k_in;
   logic signed [35:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [33:0] z_ff, z_in;
   logic [IW-1:0]      it_ff, it_in;
   logic               flip_ff, flip_in;
   logic signed [68:0] px_ff, px_in, py_ff, py_in;
   logic               out_v_ff, out_v_in;
   logic signed [15:0] a;
   logic signed [35:0] cxo, cyo;
   logic signed [33:0] at;
   logic signed [32:0] sx, sy;
   logic signed [32:0] dxv, dyv;

   function automatic logic signed [31:0] sat(input logic signed [32:0] v);
      if (v > 33'sd2147483647)       sat = 32'sh7fffffff;
      else if (v < -33'sd2147483648) sat = 32'sh80000000;
      else                           sat = v[31:0];
   endfunction

   always_comb begin
      a   = $signed(job.heading);
      at  = $signed({4'd0, atan_turn(5'(it_ff))});
      cxo = flip_ff ? -cx_ff : cx_ff;
      cyo = flip_ff ? -cy_ff : cy_ff;
      dxv = 33'(px_ff + (69'sd1 <<< 35) >>> 36);
      dyv = 33'(py_ff + (69'sd1 <<< 35) >>> 36);
      sx  = 33'(x_ff) + dxv;
      sy  = 33'(y_ff) + dyv;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: if (!job_empty) state_in = BK_ROT;
         BK_ROT:  if (it_ff == IW'(CORDIC_ITERATIONS)) state_in = BK_MUL;
         BK_MUL:  state_in = BK_ADD;
         BK_ADD:  if (!out_v_ff || rsp_pop) state_in = BK_OUT;
         BK_OUT:  if (!out_v_ff || rsp_pop)
                     state_in = (k_ff == cnt_ff) ? BK_IDLE : BK_ROT;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      x_in = x_ff; y_in = y_ff; hd_in = hd_ff; inc_in = inc_ff; d_in = d_ff;
      cnt_in = cnt_ff; k_in = k_ff; cx_in = cx_ff; cy_in = cy_ff; z_in = z_ff;
      it_in = it_ff; flip_in = flip_ff; px_in = px_ff; py_in = py_ff;
      out_v_in = out_v_ff && !rsp_pop;
      job_pop = 1'b0;
      case (state_ff)
         BK_IDLE: if (!job_empty) begin
            job_pop = 1'b1;
            x_in = job.x; y_in = job.y; hd_in = job.heading;
            inc_in = job.inc; d_in = job.step_dist; cnt_in = job.count; k_in = 7'd0;
         end
         BK_ROT: begin
            if (it_ff == IW'(CORDIC_ITERATIONS)) begin
               px_in = $signed({1'b0, d_ff}) * 69'(cxo);
               py_in = $signed({1'b0, d_ff}) * 69'(cyo);
            end else begin
               if (z_ff >= 0) begin
                  cx_in = cx_ff - (cy_ff >>> it_ff);
                  cy_in = cy_ff + (cx_ff >>> it_ff);
                  z_in  = z_ff - at;
               end else begin
                  cx_in = cx_ff + (cy_ff >>> it_ff);
                  cy_in = cy_ff - (cx_ff >>> it_ff);
                  z_in  = z_ff + at;
               end
               it_in = it_ff + IW'(1);
            end
         end
         BK_ADD: if (!out_v_ff || rsp_pop) begin
            x_in = sat(sx); y_in = sat(sy);
            hd_in = hd_ff + inc_ff;
            k_in = k_ff + 7'd1;
            out_v_in = 1'b1;
         end
         default: ;
      endcase
      // prepare CORDIC for the current heading when a step starts
      if ((state_ff == BK_IDLE && !job_empty) ||
          (state_ff == BK_OUT && (!out_v_ff || rsp_pop) && k_ff != cnt_ff)) begin
         logic signed [15:0] h;
         logic signed [16:0] f;
         h = (state_ff == BK_IDLE) ? a : $signed(hd_ff);
         f = 17'(h);
         flip_in = 1'b0;
         if (h > 16'sd16384) begin
            f = 17'(h) - 17'sd32768; flip_in = 1'b1;
         end else if (h < -16'sd16384) begin
            f = 17'(h) + 17'sd32768; flip_in = 1'b1;
         end
         z_in  = 34'(f) <<< 16;
         cx_in = INV_GAIN_Q30;
         cy_in = 36'sd0;
         it_in = '0;
      end
   end

   // the pose register is only loaded in BK_ADD when free or being popped; BK_ADD waits
   logic add_go;
   assign add_go = (state_ff == BK_ADD) && (!out_v_ff || rsp_pop);

   logic signed [31:0] ox_ff, oy_ff;
   logic [15:0]        oh_ff;
   logic [5:0]         oi_ff;
   logic               ol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
      end
      x_ff <= x_in; y_ff <= y_in; hd_ff <= hd_in; inc_ff <= inc_in; d_ff <= d_in;
      cnt_ff <= cnt_in; k_ff <= k_in; cx_ff <= cx_in; cy_ff <= cy_in;
      z_ff <= z_in; it_ff <= it_in; flip_ff <= flip_in; px_ff <= px_in;
      py_ff <= py_in;
      if (add_go) begin
         ox_ff <= sat(sx);
         oy_ff <= sat(sy);
         oh_ff <= hd_ff + inc_ff;
         oi_ff <= k_ff[5:0];
         ol_ff <= (k_ff + 7'd1 == cnt_ff);
      end
   end

   assign rsp_empty        = !out_v_ff;
   assign rsp_pose_x       = ox_ff;
   assign rsp_pose_y       = oy_ff;
   assign rsp_pose_heading = oh_ff;
   assign rsp_step_index   = oi_ff;
   assign rsp_last_step    = ol_ff;

`ifndef SYNTHESIS
   a_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff != BK_IDLE) |-> (k_ff <= cnt_ff))
      else $error("step index past run length");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_pop) |=> $stable(ox_ff) && $stable(oi_ff))
      else $error("pose changed while waiting");
   a_iter: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_ROT) |-> (it_ff <= IW'(CORDIC_ITERATIONS)))
      else $error("CORDIC count overrun");
`endif
endmodule
`default_nettype wire
